// File: rtl/core/cqf_pkg.sv
package cqf_pkg;

   // queue geometry
   localparam int DEPTH = 8;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int WORD_W = 32;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [1:0] action_type;
   typedef logic [1:0] status_type;

   localparam idx_type IDX_LAST = idx_type'(DEPTH - 1);
   localparam cnt_type CNT_FULL = cnt_type'(DEPTH);
   localparam cnt_type CNT_ONE = cnt_type'(1);

   // request action codes
   localparam action_type ACT_INSERT = 2'd0;
   localparam action_type ACT_REMOVE = 2'd1;
   localparam action_type ACT_DISPLAY = 2'd2;

   // result status codes
   localparam status_type STS_OK = 2'd0;
   localparam status_type STS_OVERFLOW = 2'd1;
   localparam status_type STS_UNDERFLOW = 2'd2;
   localparam status_type STS_EMPTY = 2'd3;

   typedef struct packed {
      action_type action;
      logic signed [WORD_W-1:0] data_value;
   } req_type;

   typedef struct packed {
      status_type status;
      logic signed [WORD_W-1:0] value;
      logic last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic do_insert;
      logic do_remove;
      logic start_walk;
      logic step_walk;
      logic load_status;
      logic load_read;
      status_type out_status;
      logic out_last;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;
      logic empty;
      logic walk_last;
   } sts_type;

   function automatic idx_type next_pos(input idx_type p);
      return (p == IDX_LAST) ? '0 : p + idx_type'(1);
   endfunction

endpackage

// File: rtl/core/cqf_datapath.sv
module cqf_datapath (
   input  logic clock,
   input  logic reset,
   input  cqf_pkg::cmd_type cmd,
   input  logic signed [cqf_pkg::WORD_W-1:0] data_value,
   output cqf_pkg::sts_type sts,
   output cqf_pkg::rsp_type rsp_data
);

   logic signed [cqf_pkg::WORD_W-1:0] mem_ff [cqf_pkg::DEPTH];
   logic signed [cqf_pkg::WORD_W-1:0] rd_data_ff;
   cqf_pkg::idx_type rd_addr;

   cqf_pkg::idx_type head_ff, head_in;
   cqf_pkg::idx_type tail_ff, tail_in;
   cqf_pkg::idx_type walk_ff, walk_in;
   cqf_pkg::cnt_type count_ff, count_in;
   cqf_pkg::cnt_type left_ff, left_in;
   cqf_pkg::rsp_type rsp_ff, rsp_in;

   // read the head, or the next word of a display walk
   assign rd_addr = cmd.step_walk ? cqf_pkg::next_pos(walk_ff) : head_ff;

   always_ff @(posedge clock) begin
      if (cmd.do_insert) begin
         mem_ff[tail_ff] <= data_value;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   always_comb begin
      head_in = cmd.do_remove ? cqf_pkg::next_pos(head_ff) : head_ff;
      tail_in = cmd.do_insert ? cqf_pkg::next_pos(tail_ff) : tail_ff;
      count_in = count_ff;
      if (cmd.do_insert) begin
         count_in = count_ff + cqf_pkg::CNT_ONE;
      end else if (cmd.do_remove) begin
         count_in = count_ff - cqf_pkg::CNT_ONE;
      end
      walk_in = walk_ff;
      left_in = left_ff;
      if (cmd.start_walk) begin
         walk_in = head_ff;
         left_in = count_ff;
      end else if (cmd.step_walk) begin
         walk_in = cqf_pkg::next_pos(walk_ff);
         left_in = left_ff - cqf_pkg::CNT_ONE;
      end
      rsp_in = rsp_ff;
      if (cmd.load_status) begin
         rsp_in.status = cmd.out_status;
         rsp_in.value = '0;
         rsp_in.last = cmd.out_last;
      end else if (cmd.load_read) begin
         rsp_in.status = cqf_pkg::STS_OK;
         rsp_in.value = rd_data_ff;
         rsp_in.last = cmd.out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         walk_ff <= '0;
         count_ff <= '0;
         left_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         walk_ff <= walk_in;
         count_ff <= count_in;
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign sts.full = (count_ff == cqf_pkg::CNT_FULL);
   assign sts.empty = (count_ff == '0);
   assign sts.walk_last = (left_ff == cqf_pkg::CNT_ONE);
   assign rsp_data = rsp_ff;

   // occupancy never exceeds the depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cqf_pkg::CNT_FULL)
      else $error("occupancy above depth");

   // pointers meet exactly when the queue is empty or full
   a_ptr_meet: assert property (@(posedge clock) disable iff (reset)
      (head_ff == tail_ff) == (sts.empty || sts.full))
      else $error("head/tail inconsistent with occupancy");

   // the controller never writes into a full queue
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      cmd.do_insert |-> !sts.full)
      else $error("insert into full queue");

endmodule

// File: rtl/core/cqf_controller.sv
module cqf_controller (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  cqf_pkg::action_type req_action,
   output logic req_stall,
   output logic rsp_valid,
   input  logic rsp_stall,
   input  cqf_pkg::sts_type sts,
   output cqf_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_READ = 3'b010,
      S_RESP = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic disp_ff, disp_in;

   always_comb begin
      state_in = state_ff;
      disp_in = disp_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_action)
                  cqf_pkg::ACT_INSERT: begin
                     cmd.load_status = 1'b1;
                     cmd.out_last = 1'b1;
                     if (sts.full) begin
                        cmd.out_status = cqf_pkg::STS_OVERFLOW;
                     end else begin
                        cmd.out_status = cqf_pkg::STS_OK;
                        cmd.do_insert = 1'b1;
                     end
                     state_in = S_RESP;
                  end
                  cqf_pkg::ACT_REMOVE: begin
                     if (sts.empty) begin
                        cmd.load_status = 1'b1;
                        cmd.out_status = cqf_pkg::STS_UNDERFLOW;
                        cmd.out_last = 1'b1;
                        state_in = S_RESP;
                     end else begin
                        cmd.do_remove = 1'b1;
                        disp_in = 1'b0;
                        state_in = S_READ;
                     end
                  end
                  cqf_pkg::ACT_DISPLAY: begin
                     if (sts.empty) begin
                        cmd.load_status = 1'b1;
                        cmd.out_status = cqf_pkg::STS_EMPTY;
                        cmd.out_last = 1'b1;
                        state_in = S_RESP;
                     end else begin
                        cmd.start_walk = 1'b1;
                        disp_in = 1'b1;
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_READ: begin
            cmd.load_read = 1'b1;
            cmd.out_last = !disp_ff || sts.walk_last;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) begin
               if (disp_ff && !sts.walk_last) begin
                  cmd.step_walk = 1'b1;
                  state_in = S_READ;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         disp_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         disp_ff <= disp_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   // a memory read always turns into a result on the next cycle
   a_read_to_resp: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |=> state_ff == S_RESP)
      else $error("read not followed by result");

   // a display walk only steps past a word that was not the last one
   a_step_not_last: assert property (@(posedge clock) disable iff (reset)
      cmd.step_walk |-> (disp_ff && !sts.walk_last && !rsp_stall))
      else $error("display walk stepped past its end");

endmodule

// File: rtl/core/circular_queue_fifo_unit.sv
// Bounded circular FIFO of signed 32-bit words, cqf_pkg::DEPTH entries deep
// (8 by default). Each request carries an action: insert writes data_value at
// the tail (status overflow if full, queue unchanged), remove returns the
// head word (status underflow if empty), display streams every held word
// oldest first with last on the final one, or a single empty result. Every
// request gives at least one result and the final one has last set; unused
// action code 3 is dropped with no result. One request is in flight at a
// time: req_stall stays high from acceptance until the last result is taken.
// Each word that a remove or a display returns is read through the registered
// read port of the storage memory before it is loaded into the result register.
// Storage needs no clearing after reset; the block is ready at once.
module circular_queue_fifo_unit (
   input  logic clock,
   input  logic reset,
   // request channel
   input  logic req_valid,
   output logic req_stall,
   input  cqf_pkg::req_type req_data,
   // result channel
   output logic rsp_valid,
   input  logic rsp_stall,
   output cqf_pkg::rsp_type rsp_data
);

   // command and status between sequencer and queue datapath
   cqf_pkg::cmd_type cmd;
   cqf_pkg::sts_type sts;

   // sequencer: decodes the action, walks the display, holds the result
   cqf_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   // storage memory, head/tail pointers, occupancy and result register
   cqf_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .data_value (req_data.data_value),
      .sts        (sts),
      .rsp_data   (rsp_data)
   );

endmodule

// File: sim/cqf_queue_checker.sv
`timescale 1ns / 1ps

// watches both channels of the queue, mirrors its contents and checks each result
module cqf_queue_checker
   import cqf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      results_owed
);

   logic signed [WORD_W-1:0] held_words[$];
   rsp_type expected_results[$];
   int mismatches;

   initial begin
      fail_count = 0;
      results_owed = 0;
      mismatches = 0;
   end

   // mirror of the queue: works out the results one request causes
   task automatic predict_request(input req_type rq);
      rsp_type r;
      r = '0;
      r.last = 1'b1;
      case (rq.action)
         ACT_INSERT: begin
            if (held_words.size() >= DEPTH) begin
               r.status = STS_OVERFLOW;
            end else begin
               held_words.push_back(rq.data_value);
               r.status = STS_OK;
            end
            expected_results.push_back(r);
         end
         ACT_REMOVE: begin
            if (held_words.size() == 0) begin
               r.status = STS_UNDERFLOW;
            end else begin
               r.status = STS_OK;
               r.value = held_words.pop_front();
            end
            expected_results.push_back(r);
         end
         ACT_DISPLAY: begin
            if (held_words.size() == 0) begin
               r.status = STS_EMPTY;
               expected_results.push_back(r);
            end else begin
               foreach (held_words[i]) begin
                  r.status = STS_OK;
                  r.value = held_words[i];
                  r.last = (i == held_words.size() - 1);
                  expected_results.push_back(r);
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (expected_results.size() == 0) begin
         $error("unexpected result: status %0d value %0d last %0d",
                got.status, got.value, got.last);
         mismatches++;
      end else begin
         want = expected_results.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            mismatches++;
         end
         if (got.value !== want.value) begin
            $error("value: expected %0d, actual %0d", want.value, got.value);
            mismatches++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            mismatches++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held_words.delete();
         expected_results.delete();
      end else begin
         if (req_valid && !req_stall) predict_request(req_data);
         if (rsp_valid && !rsp_stall) check_result(rsp_data);
      end
      fail_count <= mismatches;
      results_owed <= expected_results.size();
   end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
   import cqf_pkg::*;

   localparam int HALF_PERIOD = 10;
   localparam int RESET_CYCLES = 6;
   localparam int RANDOM_ITEMS = 200;
   // no acceptance on either channel for this long means the block is hung
   localparam int IDLE_LIMIT = 1000;
   // settle time after the drain, scaled by the queue depth plus margin
   localparam int SETTLE_CYCLES = 4 * DEPTH + 8;
   // action code the block drops without a result
   localparam action_type ACT_UNUSED = 2'd3;

   localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
   localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int fail_count;
   int results_owed;
   int burst_left = 0;
   int idle_cycles = 0;

   // stall pattern state for the result side
   int stall_mode = 0;
   int stall_left = 0;
   int stall_tick = 0;

   always #HALF_PERIOD clock = ~clock;

   circular_queue_fifo_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   cqf_queue_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .fail_count   (fail_count),
      .results_owed (results_owed)
   );

   // result side back-pressure: segments of random length, each with its own pattern
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(10, 60);
      end else begin
         stall_left = stall_left - 1;
      end
      stall_tick = stall_tick + 1;
      case (stall_mode)
         0: rsp_stall <= 1'b0;                                  // free flowing
         1: rsp_stall <= 1'($urandom_range(0, 1));              // coin flip
         2: rsp_stall <= ($urandom_range(0, 3) != 0);           // mostly stalled
         default: rsp_stall <= (stall_tick % 3 == 0);           // periodic
      endcase
   end

   // watchdog on cycles in which neither channel moves anything
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("** circular_queue_fifo_unit: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // drives one request, opening a random gap when a burst runs out
   task automatic send_request(input action_type act, input logic signed [WORD_W-1:0] word);
      req_type rq;
      int gap;
      rq.action = act;
      rq.data_value = word;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= rq;
      // hold the request until the block takes it
      do @(posedge clock); while (req_stall);
   endtask

   // idle the request side until every pending result has come back
   task automatic hold_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (results_owed != 0) @(posedge clock);
   endtask

   function automatic logic signed [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0: return WORD_MAX;
         1: return WORD_MIN;
         2: return '0;
         3: return -1;
         default: return $urandom();
      endcase
   endfunction

   initial begin
      int counted;
      int pick;
      bit filling;
      action_type act;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty queue cases and the dropped action code
      send_request(ACT_DISPLAY, '0);
      send_request(ACT_REMOVE, 32'sh1234_5678);
      send_request(ACT_UNUSED, '0);

      // fill to the brim with extreme and alternating bit patterns
      send_request(ACT_INSERT, WORD_MAX);
      send_request(ACT_INSERT, WORD_MIN);
      send_request(ACT_INSERT, '0);
      send_request(ACT_INSERT, -1);
      send_request(ACT_INSERT, 32'sh0000_0001);
      send_request(ACT_INSERT, 32'sh5555_5555);
      send_request(ACT_INSERT, 32'shaaaa_aaaa);
      send_request(ACT_INSERT, 32'sh1234_5678);

      // insert into a full queue, then show all of it
      send_request(ACT_INSERT, 32'sh0bad_f00d);
      send_request(ACT_DISPLAY, '0);
      send_request(ACT_UNUSED, -1);

      // move head forward, then push tail around the end of storage
      repeat (3) send_request(ACT_REMOVE, '0);
      send_request(ACT_INSERT, 32'sh7654_3210);
      send_request(ACT_INSERT, -2);
      send_request(ACT_INSERT, 32'sh0f0f_0f0f);
      send_request(ACT_DISPLAY, '0);
      repeat (2) send_request(ACT_REMOVE, '0);
      send_request(ACT_DISPLAY, '0);

      // let everything drain before the random part
      hold_until_drained();

      // random: alternate fill and drain leanings so full and empty both come up often
      counted = 0;
      filling = 1'b1;
      while (counted < RANDOM_ITEMS) begin
         if (counted % 25 == 0) filling = 1'($urandom_range(0, 1));
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            act = ACT_UNUSED;
         end else if (pick < 15) begin
            act = ACT_DISPLAY;
         end else if (pick < (filling ? 75 : 40)) begin
            act = ACT_INSERT;
         end else begin
            act = ACT_REMOVE;
         end
         send_request(act, pick_word());
         if (act != ACT_UNUSED) counted++;
      end

      // wind down: drop valid, collect every result, then settle
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fail_count == 0 && results_owed == 0) begin
         $display("** circular_queue_fifo_unit: PASSED **");
      end else begin
         $display("** circular_queue_fifo_unit: FAILED **");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/cqf_pkg.sv
rtl/core/cqf_datapath.sv
rtl/core/cqf_controller.sv
rtl/core/circular_queue_fifo_unit.sv
sim/cqf_queue_checker.sv
sim/tb.sv
